// ----- rtl/core/cna_pkg.sv -----
// Shared widths, opcode codes and beat types of the complex arithmetic unit.
`timescale 1ns / 1ps
package cna_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;

  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1,
    OpMul = 2'd2,
    OpDiv = 2'd3
  } op_e;

  typedef struct packed {
    op_e                         opcode;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic                        overflow;
    logic                        divide_by_zero;
  } out_beat_t;

endpackage

// ----- rtl/core/complex_number_alu.sv -----
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
`timescale 1ns / 1ps
// Usage
//   Input channel: in_valid_i / in_stall_o carry one in_beat_t per beat (opcode and
//   the operands a and b). Output channel: out_valid_o / out_stall_i carry one
//   out_beat_t per beat (saturated result, overflow and divide-by-zero flags).
//   A beat moves on a rising edge with valid high and stall low.
// Depth: every opcode passes through the same stages from input beat to result beat.
//   The quotient is built by a restoring divider laid out as one compare-subtract
//   stage per quotient bit, and that chain sets the depth.
// Throughput: one beat per cycle back to back unless stalled; no state between beats.
// Stalls: the output register holds its beat while out_stall_i is high. The pipe
//   keeps moving as long as its last stage holds a bubble, so empty slots are
//   squeezed out; once the last stage holds a beat behind a held output beat, the
//   whole pipe freezes and in_stall_o rises in the same cycle. Nothing is dropped or repeated.
// Reset: rst_ni clears every valid bit at once; the block takes a beat in the
//   first cycle after reset is released.
module complex_number_alu #(
  parameter int FRAC_BITS = cna_pkg::FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cna_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cna_pkg::out_beat_t  out_beat_o
);
  import cna_pkg::*;

  localparam int W  = DataWidth;
  localparam int PW = 2 * W;                 // product width
  localparam int SW = 2 * W + 1;             // sum of two products
  localparam int RW = 3 * W + FRAC_BITS;     // divider remainder width

  localparam logic signed [W-1:0] MaxCode = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MinCode = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    op_e                  op;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic [PW-1:0]        p_dr;
    logic [PW-1:0]        p_di;
    logic signed [W:0]    sum_re;
    logic signed [W:0]    sum_im;
  } prod_t;

  typedef struct packed {
    logic                 is_div;
    logic signed [SW-1:0] val_re;
    logic signed [SW-1:0] val_im;
    logic signed [SW-1:0] n_re;
    logic signed [SW-1:0] n_im;
    logic [PW-1:0]        d;
    logic                 dz;
  } comb_t;

  typedef struct packed {
    logic                 is_div;
    logic                 dz;
    logic signed [SW-1:0] val_re;
    logic signed [SW-1:0] val_im;
    logic [RW-1:0]        rem_re;
    logic [RW-1:0]        rem_im;
    logic [W-1:0]         q_re;
    logic [W-1:0]         q_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [PW-1:0]        d;
  } div_t;

  typedef struct packed {
    logic signed [W-1:0] v;
    logic                ovf;
  } part_t;

  // Pipe advances unless a beat sits in the last stage and the output is blocked.
  logic en;
  logic out_valid_q;
  logic [W:0] dv_v_q;

  assign en         = !(out_valid_q && out_stall_i && dv_v_q[W]);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage 1: input
  logic     v1_q;
  in_beat_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_beat_i;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [PW-1:0] ar_x, ai_x, br_x, bi_x;
  prod_t s2_d, s2_q;
  logic  v2_q;

  always_comb begin
    ar_x = PW'(s1_q.a_re);
    ai_x = PW'(s1_q.a_im);
    br_x = PW'(s1_q.b_re);
    bi_x = PW'(s1_q.b_im);
    s2_d.op   = s1_q.opcode;
    s2_d.p_rr = ar_x * br_x;
    s2_d.p_ii = ai_x * bi_x;
    s2_d.p_ri = ar_x * bi_x;
    s2_d.p_ir = ai_x * br_x;
    s2_d.p_dr = br_x * br_x;
    s2_d.p_di = bi_x * bi_x;
    if (s1_q.opcode == OpSub) begin
      s2_d.sum_re = (W+1)'(s1_q.a_re) - (W+1)'(s1_q.b_re);
      s2_d.sum_im = (W+1)'(s1_q.a_im) - (W+1)'(s1_q.b_im);
    end else begin
      s2_d.sum_re = (W+1)'(s1_q.a_re) + (W+1)'(s1_q.b_re);
      s2_d.sum_im = (W+1)'(s1_q.a_im) + (W+1)'(s1_q.b_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------- stage 3: combine
  // Multiply takes its final value here; divide forms numerators and |b|^2.
  logic signed [SW-1:0] mre, mim;
  comb_t s3_d, s3_q;
  logic  v3_q;

  always_comb begin
    mre = SW'(s2_q.p_rr) - SW'(s2_q.p_ii);
    mim = SW'(s2_q.p_ri) + SW'(s2_q.p_ir);
    s3_d.n_re   = SW'(s2_q.p_rr) + SW'(s2_q.p_ii);
    s3_d.n_im   = SW'(s2_q.p_ir) - SW'(s2_q.p_ri);
    s3_d.d      = s2_q.p_dr + s2_q.p_di;
    s3_d.is_div = (s2_q.op == OpDiv);
    s3_d.dz     = (s2_q.op == OpDiv) && (s3_d.d == '0);
    case (s2_q.op)
      OpMul: begin
        s3_d.val_re = mre >>> FRAC_BITS;
        s3_d.val_im = mim >>> FRAC_BITS;
      end
      default: begin
        s3_d.val_re = SW'(s2_q.sum_re);
        s3_d.val_im = SW'(s2_q.sum_im);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  // ---------------------------------------------------------------- divider
  div_t dv_d [W+1];
  div_t dv_q [W+1];

  // Prep: magnitudes, scale by 2^FRAC_BITS, and flag quotients of 2^W or more.
  logic [SW-1:0] mag_re, mag_im;
  logic [RW-1:0] d_top;

  always_comb begin
    mag_re = s3_q.n_re[SW-1] ? SW'(-s3_q.n_re) : SW'(s3_q.n_re);
    mag_im = s3_q.n_im[SW-1] ? SW'(-s3_q.n_im) : SW'(s3_q.n_im);
    d_top  = RW'(s3_q.d) << W;
    dv_d[0].is_div = s3_q.is_div;
    dv_d[0].dz     = s3_q.dz;
    dv_d[0].val_re = s3_q.val_re;
    dv_d[0].val_im = s3_q.val_im;
    dv_d[0].rem_re = RW'(mag_re) << FRAC_BITS;
    dv_d[0].rem_im = RW'(mag_im) << FRAC_BITS;
    dv_d[0].q_re   = '0;
    dv_d[0].q_im   = '0;
    dv_d[0].neg_re = s3_q.n_re[SW-1];
    dv_d[0].neg_im = s3_q.n_im[SW-1];
    dv_d[0].big_re = dv_d[0].rem_re >= d_top;
    dv_d[0].big_im = dv_d[0].rem_im >= d_top;
    dv_d[0].d      = s3_q.d;
  end

  for (genvar s = 0; s <= W; s++) begin : g_dv
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[s] <= 1'b0;
      end else if (en) begin
        dv_v_q[s] <= (s == 0) ? v3_q : dv_v_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[s] <= dv_d[s];
      end
    end

    if (s < W) begin : g_step
      localparam int Bit = W - 1 - s;
      logic [RW:0] tr_re, tr_im;

      always_comb begin
        tr_re = {1'b0, dv_q[s].rem_re} - ({1'b0, RW'(dv_q[s].d)} << Bit);
        tr_im = {1'b0, dv_q[s].rem_im} - ({1'b0, RW'(dv_q[s].d)} << Bit);
        dv_d[s+1] = dv_q[s];
        if (!tr_re[RW]) begin
          dv_d[s+1].rem_re    = tr_re[RW-1:0];
          dv_d[s+1].q_re[Bit] = 1'b1;
        end
        if (!tr_im[RW]) begin
          dv_d[s+1].rem_im    = tr_im[RW-1:0];
          dv_d[s+1].q_im[Bit] = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- saturate, output
  function automatic part_t sat_val(input logic signed [SW-1:0] v);
    part_t r;
    if (v > SW'(MaxCode)) begin
      r.v = MaxCode;
      r.ovf = 1'b1;
    end else if (v < SW'(MinCode)) begin
      r.v = MinCode;
      r.ovf = 1'b1;
    end else begin
      r.v = v[W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic part_t sat_quo(input logic big, input logic neg,
                                   input logic [W-1:0] q);
    part_t r;
    if (big) begin
      r.v = neg ? MinCode : MaxCode;
      r.ovf = 1'b1;
    end else if (!neg) begin
      r.v   = q[W-1] ? MaxCode : q;
      r.ovf = q[W-1];
    end else if (q > MinCode) begin
      r.v = MinCode;
      r.ovf = 1'b1;
    end else begin
      r.v = -q;
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  part_t     pr, pi;
  out_beat_t out_d, out_q;

  always_comb begin
    if (dv_q[W].is_div) begin
      pr = sat_quo(dv_q[W].big_re, dv_q[W].neg_re, dv_q[W].q_re);
      pi = sat_quo(dv_q[W].big_im, dv_q[W].neg_im, dv_q[W].q_im);
    end else begin
      pr = sat_val(dv_q[W].val_re);
      pi = sat_val(dv_q[W].val_im);
    end
    if (dv_q[W].dz) begin
      out_d.res_re   = '0;
      out_d.res_im   = '0;
      out_d.overflow = 1'b0;
    end else begin
      out_d.res_re   = pr.v;
      out_d.res_im   = pi.v;
      out_d.overflow = pr.ovf | pi.ovf;
    end
    out_d.divide_by_zero = dv_q[W].dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= dv_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // ---------------------------------------------------------------- assertions
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && dv_v_q[W]))
    else $error("input stalled without a blocked beat at the pipe end");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.divide_by_zero) |->
      (out_beat_o.res_re == '0 && out_beat_o.res_im == '0 && !out_beat_o.overflow))
    else $error("zero divisor beat carries a non-zero result");

  a_ovf_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.overflow) |->
      (out_beat_o.res_re == MaxCode || out_beat_o.res_re == MinCode ||
       out_beat_o.res_im == MaxCode || out_beat_o.res_im == MinCode))
    else $error("overflow flagged without a saturated part");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en) |=> ($stable(dv_q[W]) && $stable(dv_v_q)))
    else $error("pipe moved while frozen");

endmodule
